@@ rtl/core/ufmt_pkg.sv @@
// Shared types and constants for the unsigned decimal field formatter.
`default_nettype none

package ufmt_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned FieldWidth = 6;
  localparam int unsigned TotWidth   = FieldWidth + 1;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned StepBits   = 4;
  localparam int unsigned NumSteps   = ValueWidth / StepBits;
  localparam int unsigned StepCntW   = $clog2(NumSteps);

  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharSpace = 8'd32;

  typedef logic [NumDigits-1:0][3:0] bcd_digits_t;

  typedef struct packed {
    logic [FieldWidth-1:0] min_width;
    logic [FieldWidth-1:0] prec_digits;
    logic                  prec_given;
    logic                  left_justify;
    logic                  zero_pad;
  } fmt_opts_t;

  typedef struct packed {
    logic        done;
    bcd_digits_t digits;
  } bcd_status_t;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StCount,
    StSize,
    StEmit
  } seq_state_e;

endpackage

`default_nettype wire

@@ rtl/core/ufmt_in_if.sv @@
// Input channel: value and conversion options with valid/ready handshake.
`default_nettype none

interface ufmt_in_if;
  import ufmt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;
  logic [FieldWidth-1:0] min_width;
  logic [FieldWidth-1:0] prec_digits;
  logic                  prec_given;
  logic                  left_justify;
  logic                  zero_pad;

  modport source (
    output valid, value, min_width, prec_digits, prec_given, left_justify, zero_pad,
    input  ready
  );

  modport sink (
    input  valid, value, min_width, prec_digits, prec_given, left_justify, zero_pad,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/core/ufmt_out_if.sv @@
// Output channel: one ASCII character per transaction with valid/ready handshake.
`default_nettype none

interface ufmt_out_if;
  import ufmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] text_char;
  logic                 last_char;

  modport source (
    output valid, text_char, last_char,
    input  ready
  );

  modport sink (
    input  valid, text_char, last_char,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/core/ufmt_bcd_conv.sv @@
// Iterative binary to BCD converter, four shift-add-3 steps per cycle.
`default_nettype none

module ufmt_bcd_conv (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [ufmt_pkg::ValueWidth-1:0] value_i,
  output ufmt_pkg::bcd_status_t                status_o
);
  import ufmt_pkg::*;

  logic [ValueWidth-1:0] bin_q, bin_d;
  bcd_digits_t           bcd_q, bcd_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  function automatic bcd_digits_t dd_step(bcd_digits_t d, logic b);
    bcd_digits_t a;
    bcd_digits_t r;
    a = d;
    for (int i = 0; i < NumDigits; i++) begin
      if (a[i] >= 4'd5) begin
        a[i] = a[i] + 4'd3;
      end
    end
    r[0] = {a[0][2:0], b};
    for (int i = 1; i < NumDigits; i++) begin
      r[i] = {a[i][2:0], a[i-1][3]};
    end
    return r;
  endfunction

  always_comb begin
    bcd_digits_t acc;
    acc    = bcd_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    for (int s = 0; s < StepBits; s++) begin
      acc = dd_step(acc, bin_q[ValueWidth-1-s]);
    end
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = acc;
      bin_d = bin_q << StepBits;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(NumSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.done   = done_q;
  assign status_o.digits = bcd_q;

endmodule

`default_nettype wire

@@ rtl/core/ufmt_field_seq.sv @@
// Field sequencer: sizes the field and emits padding, zeros and digits.
`default_nettype none

module ufmt_field_seq #(
  parameter int unsigned MAX_FIELD = 63
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ufmt_in_if.sink             in_i,
  ufmt_out_if.source          out_o,
  output logic                bcd_start_o,
  input  wire ufmt_pkg::bcd_status_t bcd_i
);
  import ufmt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FIELD + 1);

  seq_state_e state_q, state_d;
  fmt_opts_t  opts_q;

  logic [DigitIdxW-1:0]  nd_q, nd_d;
  logic [FieldWidth-1:0] body_q, body_d;
  logic [FieldWidth-1:0] zeros_q, zeros_d;
  logic [FieldWidth-1:0] pad_q, pad_d;
  logic [CntW-1:0]       total_q, total_d;
  logic [CntW-1:0]       k_q;
  logic                  out_valid_q;
  logic [CharWidth-1:0]  char_q, char_d;
  logic                  last_q;

  logic                  accept;
  logic                  load;
  logic                  load_last;
  logic [TotWidth-1:0]   sum7;
  logic [TotWidth-1:0]   k7;
  logic [TotWidth-1:0]   j7;
  logic [TotWidth-1:0]   idx7;
  logic [CharWidth-1:0]  pad_char;

  // Control outputs
  always_comb begin
    in_i.ready  = (state_q == StIdle);
    accept      = in_i.valid && (state_q == StIdle);
    bcd_start_o = accept;
    load        = (state_q == StEmit) && (!out_valid_q || out_o.ready);
    load_last   = ((k_q + 1'b1) == total_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StConv;
      StConv:  if (bcd_i.done) state_d = StCount;
      StCount: state_d = StSize;
      StSize:  state_d = (total_d == '0) ? StIdle : StEmit;
      StEmit:  if (load && load_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Digit count, zero value with explicit zero precision prints no digits
  always_comb begin
    nd_d = DigitIdxW'(1);
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd_i.digits[i] != 4'd0) begin
        nd_d = DigitIdxW'(i + 1);
      end
    end
    if (bcd_i.digits == '0 && opts_q.prec_given && opts_q.prec_digits == '0) begin
      nd_d = '0;
    end
  end

  // Field sizing
  always_comb begin
    if (opts_q.prec_given && opts_q.prec_digits > FieldWidth'(nd_q)) begin
      body_d = opts_q.prec_digits;
    end else begin
      body_d = FieldWidth'(nd_q);
    end
    zeros_d = body_d - FieldWidth'(nd_q);
    pad_d   = (opts_q.min_width > body_d) ? (opts_q.min_width - body_d) : '0;
    sum7    = TotWidth'(pad_d) + TotWidth'(body_d);
    if (sum7 > TotWidth'(MAX_FIELD)) begin
      total_d = CntW'(MAX_FIELD);
    end else begin
      total_d = sum7[CntW-1:0];
    end
  end

  // Character at position k
  always_comb begin
    pad_char = (opts_q.zero_pad && !opts_q.left_justify && !opts_q.prec_given) ?
               CharZero : CharSpace;
    k7   = TotWidth'(k_q);
    j7   = opts_q.left_justify ? k7 : (k7 - TotWidth'(pad_q));
    idx7 = TotWidth'(body_q) - 1'b1 - j7;
    if (!opts_q.left_justify && k7 < TotWidth'(pad_q)) begin
      char_d = pad_char;
    end else if (opts_q.left_justify && k7 >= TotWidth'(body_q)) begin
      char_d = CharSpace;
    end else if (j7 < TotWidth'(zeros_q)) begin
      char_d = CharZero;
    end else if (idx7 < TotWidth'(NumDigits)) begin
      char_d = CharZero + CharWidth'(bcd_i.digits[idx7[DigitIdxW-1:0]]);
    end else begin
      char_d = CharZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StSize) begin
        k_q <= '0;
      end else if (load) begin
        k_q <= k_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opts_q.min_width    <= in_i.min_width;
      opts_q.prec_digits  <= in_i.prec_digits;
      opts_q.prec_given   <= in_i.prec_given;
      opts_q.left_justify <= in_i.left_justify;
      opts_q.zero_pad     <= in_i.zero_pad;
    end
    if (state_q == StCount) begin
      nd_q <= nd_d;
    end
    if (state_q == StSize) begin
      body_q  <= body_d;
      zeros_q <= zeros_d;
      pad_q   <= pad_d;
      total_q <= total_d;
    end
    if (load) begin
      char_q <= char_d;
      last_q <= load_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = char_q;
  assign out_o.last_char = last_q;

`ifndef ASSERT_OFF
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StConv)
    else $error("accepted transaction did not start conversion");

  a_done_only_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_i.done |-> state_q == StConv)
    else $error("conversion done outside conversion state");

  a_index_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> k_q < total_q)
    else $error("character index beyond field length");

  a_digit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSize |-> nd_q <= DigitIdxW'(NumDigits))
    else $error("digit count out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/core/unsigned_decimal_padded_formatter_core.sv @@
// Top level of the unsigned decimal padded formatter.
// Usage:
//   in_i carries one conversion per transaction: a 32-bit unsigned value with
//   minimum width, precision, precision-given, left-justify and zero-pad flags.
//   out_o carries the formatted field as ASCII, one character per transaction,
//   with last_char set on the final character of the field.
// Timing:
//   After acceptance the value is converted to BCD by an iterative shift-add-3 unit
//   that handles four bits per cycle; the sequencer then counts digits, sizes the
//   field and loads the output register, and presents one character per cycle
//   while out_o is ready. The emitted field length is at most MAX_FIELD. A
//   zero-length field produces no transaction on out_o.
//   in_i.ready is high only between conversions; the final character may still
//   wait in the output register while the next conversion is accepted.
// Reset:
//   rst_ni clears the sequencer and drops out_o.valid; no conversion survives.
// Stall:
//   When out_o.ready is low the current character holds and the sequence pauses.
`default_nettype none

module unsigned_decimal_padded_formatter_core #(
  parameter int unsigned MAX_FIELD = 63
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ufmt_in_if.sink    in_i,
  ufmt_out_if.source out_o
);
  import ufmt_pkg::*;

  logic        bcd_start;
  bcd_status_t bcd_status;

  ufmt_bcd_conv u_bcd_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .value_i  (in_i.value),
    .status_o (bcd_status)
  );

  ufmt_field_seq #(
    .MAX_FIELD (MAX_FIELD)
  ) u_field_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .bcd_start_o (bcd_start),
    .bcd_i       (bcd_status)
  );

endmodule

`default_nettype wire

@@ tb/ufmt_tb_checker.sv @@
// Checker for the decimal formatter: predicts each field and compares every character.
`default_nettype none

module ufmt_tb_checker
  import ufmt_pkg::*;
#(
  parameter int unsigned MAX_FIELD = 63
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ufmt_in_if         in_mon,
  ufmt_out_if        out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned chars_checked_o
);

  typedef struct {
    logic [CharWidth-1:0] text_char;
    logic                 last_char;
    int unsigned          conv_idx;
  } field_char_t;

  field_char_t exp_chars_q[$];
  int unsigned conv_cnt;

  initial begin
    fail_cnt_o      = 0;
    pending_o       = 0;
    chars_checked_o = 0;
    conv_cnt        = 0;
  end

  function automatic void predict_field(input logic [ValueWidth-1:0] value,
                                        input fmt_opts_t opts);
    logic [CharWidth-1:0] digs[NumDigits];
    logic [CharWidth-1:0] line[$];
    logic [CharWidth-1:0] pad_char;
    logic [ValueWidth-1:0] rest;
    int unsigned n_digs;
    int unsigned n_zeros;
    int unsigned n_pad;
    int unsigned n_out;
    field_char_t fc;
    n_digs = 0;
    if (!(value == '0 && opts.prec_given && opts.prec_digits == '0)) begin
      rest = value;
      do begin
        digs[n_digs] = CharZero + CharWidth'(rest % 10);
        n_digs++;
        rest = rest / 10;
      end while (rest != '0 && n_digs < NumDigits);
    end
    n_zeros = (opts.prec_given && opts.prec_digits > n_digs) ? opts.prec_digits - n_digs : 0;
    n_pad   = (opts.min_width > n_zeros + n_digs) ? opts.min_width - (n_zeros + n_digs) : 0;
    pad_char = (opts.zero_pad && !opts.left_justify && !opts.prec_given) ? CharZero
                                                                           : CharSpace;
    if (!opts.left_justify) begin
      repeat (n_pad) line.push_back(pad_char);
    end
    repeat (n_zeros) line.push_back(CharZero);
    for (int k = n_digs; k > 0; k--) line.push_back(digs[k-1]);
    if (opts.left_justify) begin
      repeat (n_pad) line.push_back(CharSpace);
    end
    n_out = (line.size() > MAX_FIELD) ? MAX_FIELD : line.size();
    for (int unsigned k = 0; k < n_out; k++) begin
      fc.text_char = line[k];
      fc.last_char = (k + 1 == n_out);
      fc.conv_idx  = conv_cnt;
      exp_chars_q.push_back(fc);
    end
  endfunction

  always @(posedge clk_i) begin
    field_char_t fc;
    fmt_opts_t   opts;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        opts.min_width    = in_mon.min_width;
        opts.prec_digits  = in_mon.prec_digits;
        opts.prec_given   = in_mon.prec_given;
        opts.left_justify = in_mon.left_justify;
        opts.zero_pad     = in_mon.zero_pad;
        predict_field(in_mon.value, opts);
        conv_cnt++;
      end
      if (out_mon.valid && out_mon.ready) begin
        chars_checked_o++;
        if (exp_chars_q.size() == 0) begin
          $error("unexpected character %0d, no field pending", out_mon.text_char);
          fail_cnt_o++;
        end else begin
          fc = exp_chars_q.pop_front();
          if (out_mon.text_char !== fc.text_char) begin
            $error("conversion %0d text_char: expected %0d, got %0d",
                   fc.conv_idx, fc.text_char, out_mon.text_char);
            fail_cnt_o++;
          end
          if (out_mon.last_char !== fc.last_char) begin
            $error("conversion %0d last_char: expected %0d, got %0d",
                   fc.conv_idx, fc.last_char, out_mon.last_char);
            fail_cnt_o++;
          end
        end
      end
      pending_o = exp_chars_q.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Top of the formatter testbench: clock, reset, stimulus, receiver stalls and verdict.
`default_nettype none

module tb_top;
  import ufmt_pkg::*;

  localparam int unsigned NumRandom = 360;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned chars_checked;
  int unsigned convs_sent;
  int unsigned burst_left;
  int unsigned directed_cnt;

  ufmt_in_if  in_if ();
  ufmt_out_if out_if ();

  unsigned_decimal_padded_formatter_core #(
    .MAX_FIELD(63)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  ufmt_tb_checker #(
    .MAX_FIELD(63)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .chars_checked_o(chars_checked)
  );

  always #5 clk_i = ~clk_i;

  function automatic fmt_opts_t opts(input int unsigned w, input int unsigned p,
                                     input bit pg, input bit lj, input bit zp);
    fmt_opts_t o;
    o.min_width    = FieldWidth'(w);
    o.prec_digits  = FieldWidth'(p);
    o.prec_given   = pg;
    o.left_justify = lj;
    o.zero_pad     = zp;
    return o;
  endfunction

  function automatic logic [ValueWidth-1:0] pick_value();
    int unsigned n_digs;
    longint unsigned lo;
    longint unsigned hi;
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1, 2: begin
        return $urandom();
      end
      default: begin
        n_digs = $urandom_range(1, NumDigits);
        lo = 1;
        repeat (n_digs - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        if (n_digs == 1) lo = 0;
        return ValueWidth'(lo + ($urandom() % (hi - lo + 1)));
      end
    endcase
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 14);
  endfunction

  task automatic send_conv(input logic [ValueWidth-1:0] value, input fmt_opts_t o);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_if.valid        <= 1'b1;
    in_if.value        <= value;
    in_if.min_width    <= o.min_width;
    in_if.prec_digits  <= o.prec_digits;
    in_if.prec_given   <= o.prec_given;
    in_if.left_justify <= o.left_justify;
    in_if.zero_pad     <= o.zero_pad;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    convs_sent++;
  endtask

  // receiver: stall pattern is re-picked at random, with long hold-offs
  initial begin
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    out_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 200 == 0) mode = $urandom_range(0, 3);
      if ((cyc >= 1500 && cyc < 1900) || (cyc >= 6000 && cyc < 6300)) begin
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 7) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    convs_sent   = 0;
    burst_left   = 0;
    directed_cnt = 0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.value        <= '0;
    in_if.min_width    <= '0;
    in_if.prec_digits  <= '0;
    in_if.prec_given   <= 1'b0;
    in_if.left_justify <= 1'b0;
    in_if.zero_pad     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_conv(32'd0,          opts(0, 0, 0, 0, 0));
    send_conv(32'hFFFF_FFFF,  opts(0, 0, 0, 0, 0));
    send_conv(32'd0,          opts(0, 0, 1, 0, 0));
    send_conv(32'd0,          opts(5, 0, 1, 0, 1));
    send_conv(32'd0,          opts(63, 0, 1, 1, 0));
    send_conv(32'd0,          opts(0, 1, 1, 0, 0));
    send_conv(32'd0,          opts(63, 0, 0, 0, 1));
    send_conv(32'd42,         opts(8, 0, 0, 0, 1));
    send_conv(32'd42,         opts(8, 4, 1, 0, 1));
    send_conv(32'd42,         opts(8, 0, 0, 1, 1));
    send_conv(32'd42,         opts(8, 5, 1, 1, 0));
    send_conv(32'd123,        opts(0, 63, 1, 0, 0));
    send_conv(32'hFFFF_FFFF,  opts(63, 0, 0, 0, 1));
    send_conv(32'hFFFF_FFFF,  opts(63, 0, 0, 1, 0));
    send_conv(32'hFFFF_FFFF,  opts(63, 63, 1, 1, 1));
    send_conv(32'd12345,      opts(3, 2, 1, 0, 0));
    send_conv(32'd1000000000, opts(12, 10, 1, 0, 1));
    send_conv(32'd9,          opts(1, 0, 0, 0, 0));
    send_conv(32'd10,         opts(2, 0, 0, 0, 0));
    send_conv(32'd99,         opts(0, 0, 0, 0, 0));
    send_conv(32'd100,        opts(0, 0, 0, 0, 0));
    send_conv(32'd7,          opts(63, 62, 1, 0, 0));
    send_conv(32'd5,          opts(10, 0, 0, 0, 1));
    directed_cnt = convs_sent;

    repeat (NumRandom) begin
      send_conv(pick_value(), opts(pick_len(), pick_len(), 1'($urandom_range(0, 2) == 0),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    end
    in_if.valid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);

    $display("Summary: %0d conversions (%0d directed), %0d characters checked,",
             convs_sent, directed_cnt, chars_checked);
    $display("  with bursty input, random output stalls and long output hold-offs");
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
